// ===== rtl/core/id3p_pkg.sv =====
// Shared types, codes and helpers for the ID3v2 tag frame parser.
`default_nettype none

package id3p_pkg;

    // Result kinds
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_FRAME   = 3'd1;
    localparam logic [2:0] KIND_CONTENT = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_MAGIC     = 2'd0;
    localparam logic [1:0] ERR_VERSION   = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    // Magic and supported major versions
    localparam logic [31:0] MAGIC_ID3 = 32'h0049_4433;
    localparam logic [7:0]  VER_MAJOR_3 = 8'd3;
    localparam logic [7:0]  VER_MAJOR_4 = 8'd4;
    localparam logic [7:0]  SYNCHSAFE_MASK = 8'h7F;

    // Known frame ids
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_TRCK = 32'h5452_434B;
    localparam logic [31:0] ID_TENC = 32'h5445_4E43;
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

    localparam logic [3:0] CODE_UNKNOWN = 4'd0;
    localparam logic [3:0] CODE_TIT2    = 4'd1;
    localparam logic [3:0] CODE_TPE1    = 4'd2;
    localparam logic [3:0] CODE_TALB    = 4'd3;
    localparam logic [3:0] CODE_TYER    = 4'd4;
    localparam logic [3:0] CODE_TCON    = 4'd5;
    localparam logic [3:0] CODE_TRCK    = 4'd6;
    localparam logic [3:0] CODE_TENC    = 4'd7;
    localparam logic [3:0] CODE_COMM    = 4'd8;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_VER   = 4'd1,
        PH_HFLAG = 4'd2,
        PH_HSIZE = 4'd3,
        PH_FID   = 4'd4,
        PH_FSIZE = 4'd5,
        PH_FFLAG = 4'd6,
        PH_ENC   = 4'd7,
        PH_DATA  = 4'd8,
        PH_HALT  = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  major_version;
        logic [7:0]  revision;
        logic [31:0] frame_tag;
        logic [3:0]  frame_code;
        logic [7:0]  text_encoding;
        logic [31:0] frame_length;
        logic [7:0]  content_byte;
        logic        last_of_frame;
        logic [1:0]  error_code;
        logic        last_of_step;
    } out_item_t;

    // Events raised by one byte: up to two results
    typedef struct packed {
        logic [1:0]       count;
        logic [1:0][2:0]  kind;
        logic [1:0]       last_frame;
        logic [1:0][1:0]  err;
        logic [31:0]      tag;
    } step_ev_t;

    // Map a frame id to its known-tag code
    function automatic logic [3:0] frame_code_of(input logic [31:0] id);
        logic [3:0] code;
        case (id)
            ID_TIT2: code = CODE_TIT2;
            ID_TPE1: code = CODE_TPE1;
            ID_TALB: code = CODE_TALB;
            ID_TYER: code = CODE_TYER;
            ID_TCON: code = CODE_TCON;
            ID_TRCK: code = CODE_TRCK;
            ID_TENC: code = CODE_TENC;
            ID_COMM: code = CODE_COMM;
            default: code = CODE_UNKNOWN;
        endcase
        return code;
    endfunction

    // Build one result from the event and the parser state
    function automatic out_item_t make_result(
        input logic [2:0]  kind,
        input logic [7:0]  content,
        input logic        last_frame,
        input logic [1:0]  err,
        input logic        last_step,
        input logic [7:0]  ver,
        input logic [7:0]  rev,
        input logic [31:0] tag,
        input logic [7:0]  enc,
        input logic [31:0] fsize
    );
        out_item_t r;
        logic      fr;
        fr = (kind == KIND_FRAME) || (kind == KIND_CONTENT);
        r.kind          = kind;
        r.major_version = ver;
        r.revision      = rev;
        r.frame_tag     = fr ? tag : 32'd0;
        r.frame_code    = fr ? frame_code_of(tag) : CODE_UNKNOWN;
        r.text_encoding = fr ? enc : 8'd0;
        r.frame_length  = fr ? (fsize - 32'd1) : 32'd0;
        r.content_byte  = (kind == KIND_CONTENT) ? content : 8'd0;
        r.last_of_frame = last_frame;
        r.error_code    = (kind == KIND_ERROR) ? err : ERR_MAGIC;
        r.last_of_step  = last_step;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/id3v2_tag_frame_parser_top.sv =====
// Top level of the ID3v2 tag frame parser: byte register, step logic, result queue.
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+------------------------
//  byte    | in        | byte_valid / byte_stall        | byte_item   (in_item_t)
//  result  | out       | result_valid / result_stall    | result_item (out_item_t)
//
// One byte per cycle is taken while byte_stall is low. A transferred byte is held in the
// byte register; once the queue has room the step logic updates the parser state and
// writes up to two results into a four-entry result queue. A byte that causes two
// results fills two queue entries, read out one at a time. The byte channel stalls
// while a byte is held and fewer than two queue entries are free.
// Reset clears the parser to wait for the magic and empties the queue.
`default_nettype none

module id3v2_tag_frame_parser_top (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  byte_valid,
    output logic                 byte_stall,
    input  wire id3p_pkg::in_item_t byte_item,
    output logic                 result_valid,
    input  wire                  result_stall,
    output id3p_pkg::out_item_t  result_item
);
    import id3p_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Byte register
    logic     in_vld_reg, in_vld_next;
    in_item_t in_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [2:0]  fc_reg, fc_next;
    logic [27:0] tsz_reg, tsz_next;
    logic [31:0] tpos_reg, tpos_next;
    logic [31:0] ftag_reg, ftag_next;
    logic [31:0] fsz_reg, fsz_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  enc_reg, enc_next;
    logic [7:0]  ver_reg, ver_next;
    logic [7:0]  rev_reg, rev_next;

    step_ev_t  ev;
    out_item_t res0, res1;

    // Result queue
    out_item_t        q_mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     cnt_reg, cnt_next;

    logic byte_take, fire, pop, room;

    // Handshakes
    assign room         = cnt_reg <= (QAW+1)'(QDEPTH - 2);
    assign fire         = in_vld_reg && room;
    assign byte_stall   = in_vld_reg && !room;
    assign byte_take    = byte_valid && !byte_stall;
    assign result_valid = cnt_reg != '0;
    assign result_item  = q_mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    // Hold or refill the byte register
    always_comb
    begin
        if (byte_take)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
            in_reg <= byte_item;
    end

    // Next state: advance the parser by one byte and record the results it raises
    always_comb
    begin
        logic [7:0] b;
        logic       was_halted;
        logic       boundary;

        b          = in_reg.data_byte;
        phase_next = phase_reg;
        fc_next    = fc_reg;
        tsz_next   = tsz_reg;
        tpos_next  = tpos_reg;
        ftag_next  = ftag_reg;
        fsz_next   = fsz_reg;
        rem_next   = rem_reg;
        enc_next   = enc_reg;
        ver_next   = ver_reg;
        rev_next   = rev_reg;
        ev         = '0;
        boundary   = 1'b0;

        // Restart at offset zero
        if (in_reg.start_of_file)
        begin
            phase_next = PH_MAGIC;
            fc_next    = '0;
            tsz_next   = '0;
            tpos_next  = '0;
            ftag_next  = '0;
            fsz_next   = '0;
            rem_next   = '0;
            enc_next   = '0;
            ver_next   = '0;
            rev_next   = '0;
        end
        was_halted = (phase_next == PH_HALT);

        case (phase_next)
            PH_MAGIC:
            begin
                ftag_next = {8'd0, ftag_next[15:0], b};
                fc_next   = fc_next + 3'd1;
                if (fc_next >= 3'd3)
                begin
                    if (ftag_next == MAGIC_ID3)
                    begin
                        phase_next = PH_VER;
                        fc_next    = '0;
                    end
                    else
                    begin
                        ev.kind[ev.count[0]] = KIND_ERROR;
                        ev.err[ev.count[0]]  = ERR_MAGIC;
                        ev.count             = ev.count + 2'd1;
                        phase_next           = PH_HALT;
                    end
                    ftag_next = '0;
                end
            end
            PH_VER:
            begin
                if (fc_next == 3'd0)
                begin
                    ver_next = b;
                    fc_next  = 3'd1;
                end
                else
                begin
                    rev_next = b;
                    fc_next  = '0;
                    if (ver_next == VER_MAJOR_3 || ver_next == VER_MAJOR_4)
                        phase_next = PH_HFLAG;
                    else
                    begin
                        ev.kind[ev.count[0]] = KIND_ERROR;
                        ev.err[ev.count[0]]  = ERR_VERSION;
                        ev.count             = ev.count + 2'd1;
                        phase_next           = PH_HALT;
                    end
                end
            end
            PH_HFLAG:
            begin
                phase_next = PH_HSIZE;
                fc_next    = '0;
                tsz_next   = '0;
            end
            PH_HSIZE:
            begin
                tsz_next = {tsz_next[20:0], b[6:0] & SYNCHSAFE_MASK[6:0]};
                fc_next  = fc_next + 3'd1;
                if (fc_next >= 3'd4)
                begin
                    ev.kind[ev.count[0]] = KIND_HEADER;
                    ev.count             = ev.count + 2'd1;
                    tpos_next            = '0;
                    boundary             = 1'b1;
                end
            end
            PH_FID:
            begin
                if (tpos_next != '1)
                    tpos_next = tpos_next + 32'd1;
                ftag_next = {ftag_next[23:0], b};
                fc_next   = fc_next + 3'd1;
                if (fc_next >= 3'd4)
                begin
                    if (ftag_next[31:24] == 8'd0)
                    begin
                        ev.kind[ev.count[0]] = KIND_DONE;
                        ev.count             = ev.count + 2'd1;
                        phase_next           = PH_HALT;
                    end
                    else
                    begin
                        phase_next = PH_FSIZE;
                        fc_next    = '0;
                        fsz_next   = '0;
                    end
                end
            end
            PH_FSIZE:
            begin
                if (tpos_next != '1)
                    tpos_next = tpos_next + 32'd1;
                fsz_next = {fsz_next[23:0], b};
                fc_next  = fc_next + 3'd1;
                if (fc_next >= 3'd4)
                begin
                    if (fsz_next == 32'd0)
                    begin
                        ev.kind[ev.count[0]] = KIND_DONE;
                        ev.count             = ev.count + 2'd1;
                        phase_next           = PH_HALT;
                    end
                    else
                    begin
                        phase_next = PH_FFLAG;
                        fc_next    = '0;
                    end
                end
            end
            PH_FFLAG:
            begin
                if (tpos_next != '1)
                    tpos_next = tpos_next + 32'd1;
                fc_next = fc_next + 3'd1;
                if (fc_next >= 3'd2)
                begin
                    phase_next = PH_ENC;
                    fc_next    = '0;
                end
            end
            PH_ENC:
            begin
                if (tpos_next != '1)
                    tpos_next = tpos_next + 32'd1;
                enc_next                   = b;
                rem_next                   = fsz_next - 32'd1;
                ev.kind[ev.count[0]]       = KIND_FRAME;
                ev.last_frame[ev.count[0]] = (rem_next == 32'd0);
                ev.count                   = ev.count + 2'd1;
                if (rem_next == 32'd0)
                    boundary = 1'b1;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (tpos_next != '1)
                    tpos_next = tpos_next + 32'd1;
                rem_next                   = rem_next - 32'd1;
                ev.kind[ev.count[0]]       = KIND_CONTENT;
                ev.last_frame[ev.count[0]] = (rem_next == 32'd0);
                ev.count                   = ev.count + 2'd1;
                if (rem_next == 32'd0)
                    boundary = 1'b1;
            end
            PH_HALT:
            begin
                phase_next = PH_HALT;
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase

        // Frame fields of the results come from the id before any boundary clear
        ev.tag = ftag_next;

        // Between frames: finish the tag or open the next frame
        if (boundary)
        begin
            if (tpos_next >= {4'd0, tsz_next})
            begin
                ev.kind[ev.count[0]] = KIND_DONE;
                ev.count             = ev.count + 2'd1;
                phase_next           = PH_HALT;
            end
            else
            begin
                phase_next = PH_FID;
                fc_next    = '0;
                ftag_next  = '0;
            end
        end

        // Input ended with the parse unfinished
        if (in_reg.end_of_file && !was_halted && phase_next != PH_HALT)
        begin
            ev.kind[ev.count[0]] = KIND_ERROR;
            ev.err[ev.count[0]]  = ERR_TRUNCATED;
            ev.count             = ev.count + 2'd1;
            phase_next           = PH_HALT;
        end
    end

    // Outputs: build the results of this byte
    always_comb
    begin
        res0 = make_result(ev.kind[0], in_reg.data_byte, ev.last_frame[0], ev.err[0],
                           ev.count == 2'd1, ver_next, rev_next, ev.tag, enc_next,
                           fsz_next);
        res1 = make_result(ev.kind[1], in_reg.data_byte, ev.last_frame[1], ev.err[1],
                           1'b1, ver_next, rev_next, ev.tag, enc_next, fsz_next);
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            fc_reg    <= '0;
            tsz_reg   <= '0;
            tpos_reg  <= '0;
            ftag_reg  <= '0;
            fsz_reg   <= '0;
            rem_reg   <= '0;
            enc_reg   <= '0;
            ver_reg   <= '0;
            rev_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            tsz_reg   <= tsz_next;
            tpos_reg  <= tpos_next;
            ftag_reg  <= ftag_next;
            fsz_reg   <= fsz_next;
            rem_reg   <= rem_next;
            enc_reg   <= enc_next;
            ver_reg   <= ver_next;
            rev_reg   <= rev_next;
        end
    end

    // Queue pointers and fill count
    always_comb
    begin
        logic [1:0] push_n;
        push_n      = fire ? ev.count : 2'd0;
        wr_ptr_next = wr_ptr_reg + QAW'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (QAW+1)'(push_n) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write the results of this byte into the queue
    always_ff @(posedge clk)
    begin
        if (fire && ev.count != 2'd0)
            q_mem[wr_ptr_reg] <= res0;
        if (fire && ev.count == 2'd2)
            q_mem[wr_ptr_reg + QAW'(1)] <= res1;
    end

endmodule

`default_nettype wire
